@@ rtl/tdsd_pkg.sv @@
package tdsd_pkg;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_VARINT,
    PH_FIXED,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TRUNC,
    ERR_VARINT_LONG,
    ERR_LEN_BIG
  } err_t;

  localparam logic [3:0] DT_NULL   = 4'd0;
  localparam logic [3:0] DT_BOOL   = 4'd1;
  localparam logic [3:0] DT_INT32  = 4'd2;
  localparam logic [3:0] DT_UINT32 = 4'd3;
  localparam logic [3:0] DT_INT64  = 4'd4;
  localparam logic [3:0] DT_UINT64 = 4'd5;
  localparam logic [3:0] DT_IPV4   = 4'd6;
  localparam logic [3:0] DT_IPV6   = 4'd7;
  localparam logic [3:0] DT_STR    = 4'd8;
  localparam logic [3:0] DT_BIN    = 4'd9;

  localparam logic [7:0] VARINT_ESC     = 8'd240;
  localparam logic [3:0] VARINT_MAX_IDX = 4'd9;
  localparam logic [7:0] BOOL_FLAG      = 8'h10;

  typedef struct packed {
    logic [3:0]  data_type;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        last;
    err_t        error_code;
  } result_t;

endpackage

@@ rtl/tdsd_decode.sv @@
module tdsd_decode
  import tdsd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] cur_byte,
  input  logic       cur_frame_end,
  output logic       res_vld,
  output result_t    res
);

  localparam int REM_W = $clog2(MAX_FRAME_BYTES + 1);

  phase_t           phase_r, phase_nxt;
  logic [3:0]       held_r, held_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [63:0]      upper_r, upper_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      held_r  <= '0;
      acc_r   <= '0;
      idx_r   <= '0;
      rem_r   <= '0;
      upper_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
      rem_r   <= rem_nxt;
      upper_r <= upper_nxt;
    end
  end

  logic [5:0]       shamt;
  logic [63:0]      sum;
  logic [63:0]      sh_acc;
  logic [63:0]      sh_upper;
  logic [REM_W-1:0] rem_dec;
  logic             clr;
  phase_t           ph_tgt;
  logic [REM_W-1:0] rem_load;
  logic             done;
  logic [63:0]      done_val;
  logic             fail;
  err_t             fail_code;

  always_comb begin
    shamt    = 6'(7 * idx_r) - 6'd3;
    sum      = acc_r + (64'(cur_byte) << shamt);
    sh_acc   = {acc_r[55:0], cur_byte};
    sh_upper = {upper_r[55:0], acc_r[63:56]};
    rem_dec  = (rem_r != '0) ? rem_r - REM_W'(1) : rem_r;

    phase_nxt = phase_r;
    held_nxt  = held_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    upper_nxt = upper_r;

    res_vld        = 1'b0;
    res            = '0;
    res.data_type  = held_r;
    res.error_code = ERR_NONE;

    clr       = 1'b0;
    ph_tgt    = PH_TYPE;
    rem_load  = '0;
    done      = 1'b0;
    done_val  = '0;
    fail      = 1'b0;
    fail_code = ERR_NONE;

    unique case (phase_r)
      PH_VARINT: begin
        if (idx_r == '0) begin
          if (cur_byte < VARINT_ESC) begin
            done     = 1'b1;
            done_val = 64'(cur_byte);
          end else begin
            acc_nxt = 64'(cur_byte);
            idx_nxt = 4'd1;
            if (cur_frame_end) begin
              fail      = 1'b1;
              fail_code = ERR_TRUNC;
            end
          end
        end else if (idx_r > VARINT_MAX_IDX) begin
          fail      = 1'b1;
          fail_code = ERR_VARINT_LONG;
        end else if (cur_byte[7]) begin
          if (idx_r == VARINT_MAX_IDX) begin
            fail      = 1'b1;
            fail_code = ERR_VARINT_LONG;
          end else if (cur_frame_end) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNC;
          end else begin
            acc_nxt = sum;
            idx_nxt = idx_r + 4'd1;
          end
        end else begin
          done     = 1'b1;
          done_val = sum;
        end
      end
      PH_FIXED: begin
        upper_nxt = sh_upper;
        acc_nxt   = sh_acc;
        rem_nxt   = rem_dec;
        if (rem_dec == '0) begin
          clr            = 1'b1;
          res_vld        = 1'b1;
          res.value_low  = sh_acc;
          res.value_high = sh_upper;
          res.last       = 1'b1;
        end else if (cur_frame_end) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNC;
        end
      end
      PH_PAYLOAD: begin
        rem_nxt          = rem_dec;
        res_vld          = 1'b1;
        res.payload_byte = cur_byte;
        res.is_payload   = 1'b1;
        if (rem_dec == '0) begin
          clr      = 1'b1;
          res.last = 1'b1;
        end else if (cur_frame_end) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNC;
        end
      end
      default: begin
        clr           = 1'b1;
        held_nxt      = cur_byte[3:0];
        res.data_type = cur_byte[3:0];
        unique case (cur_byte[3:0]) inside
          DT_BOOL: begin
            res_vld       = 1'b1;
            res.value_low = 64'((cur_byte & BOOL_FLAG) != 8'd0);
            res.last      = 1'b1;
          end
          DT_INT32, DT_UINT32, DT_INT64, DT_UINT64, DT_STR, DT_BIN: begin
            ph_tgt = PH_VARINT;
          end
          DT_IPV4: begin
            ph_tgt   = PH_FIXED;
            rem_load = REM_W'(4);
          end
          DT_IPV6: begin
            ph_tgt   = PH_FIXED;
            rem_load = REM_W'(16);
          end
          default: begin
            res_vld  = 1'b1;
            res.last = 1'b1;
          end
        endcase
        if (!res_vld && cur_frame_end) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNC;
        end
      end
    endcase

    if (done) begin
      clr = 1'b1;
      if (held_r == DT_STR || held_r == DT_BIN) begin
        if (done_val > 64'(MAX_FRAME_BYTES)) begin
          fail      = 1'b1;
          fail_code = ERR_LEN_BIG;
        end else if (done_val == '0) begin
          res_vld  = 1'b1;
          res.last = 1'b1;
        end else if (cur_frame_end) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNC;
        end else begin
          ph_tgt        = PH_PAYLOAD;
          rem_load      = REM_W'(done_val);
          res_vld       = 1'b1;
          res.value_low = done_val;
        end
      end else begin
        res_vld       = 1'b1;
        res.value_low = done_val;
        res.last      = 1'b1;
      end
    end

    if (fail) begin
      clr            = 1'b1;
      ph_tgt         = PH_TYPE;
      rem_load       = '0;
      res_vld        = 1'b1;
      res.value_low  = '0;
      res.value_high = '0;
      res.last       = 1'b1;
      res.error_code = fail_code;
    end

    if (clr) begin
      phase_nxt = ph_tgt;
      acc_nxt   = '0;
      idx_nxt   = '0;
      rem_nxt   = rem_load;
      upper_nxt = '0;
    end
  end

endmodule

@@ rtl/typed_data_stream_decoder_core.sv @@
// channel | valid     | stall     | payload
// --------+-----------+-----------+---------------------------------------------
// in      | in_valid  | in_stall  | in_byte, in_frame_end
// out     | out_valid | out_stall | out_data_type, out_value_low/high,
//         |           |           | out_payload_byte, out_is_payload, out_last,
//         |           |           | out_error_code
//
// One input item per cycle while in_stall is low.
// Path: input register -> decode step against element state -> result register.
// An item that produces no result still takes one step slot.
// out_stall holds the result register; in_stall rises when the input register
// is full and the result register cannot take its step.
// rst_n is synchronous; no clearing pass, the block accepts right after reset.
module typed_data_stream_decoder_core
  import tdsd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_data_type,
  output logic [63:0] out_value_low,
  output logic [63:0] out_value_high,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_payload,
  output logic        out_last,
  output logic [1:0]  out_error_code
);

  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_fe_r;
  logic       out_vld_r;
  result_t    out_res_r;
  logic       out_free;
  logic       step;
  logic       res_vld;
  result_t    res;

  assign out_free = !out_vld_r || !out_stall;
  assign step     = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
      s1_fe_r   <= in_frame_end;
    end
  end

  tdsd_decode #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .cur_byte     (s1_byte_r),
    .cur_frame_end(s1_fe_r),
    .res_vld      (res_vld),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_data_type    = out_res_r.data_type;
  assign out_value_low    = out_res_r.value_low;
  assign out_value_high   = out_res_r.value_high;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_is_payload   = out_res_r.is_payload;
  assign out_last         = out_res_r.last;
  assign out_error_code   = out_res_r.error_code;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |-> out_last)
    else $error("error result without last");

  a_payload_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_payload |->
      (out_error_code == ERR_NONE || out_error_code == ERR_TRUNC))
    else $error("payload result with varint or length error");

  a_high_ipv6: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value_high != '0) |-> (out_data_type == DT_IPV6))
    else $error("upper half set on non-ipv6 element");

  a_no_stray_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_payload |-> (out_payload_byte == '0))
    else $error("payload byte on header result");

endmodule
